// ===== hdl/windowed_nearest_opaque_distance_unit_macros.svh =====
// Assertion macros shared by the windowed nearest distance unit.
`ifndef WINDOWED_NEAREST_OPAQUE_DISTANCE_UNIT_MACROS_SVH
`define WINDOWED_NEAREST_OPAQUE_DISTANCE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WNOD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WNOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WNOD_ASSERT_IMP(label, clk, rst, ante, cons)
`define WNOD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/wnod_pkg.sv =====
// Shared types and constants of the windowed nearest distance unit.
package wnod_pkg;
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 31;
   localparam logic [7:0] FULL_ALPHA = 8'd255;
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic write_pixel;
      logic start_query;
      logic scan_step;
      logic start_sqrt;
      logic sqrt_step;
   } cmd_type;

   typedef struct packed {
      logic opaque_hit;
      logic scan_last;
      logic sqrt_done;
   } status_type;
endpackage

// ===== hdl/windowed_nearest_opaque_distance_unit.sv =====
// Top level of the windowed nearest distance unit.
//  channel | handshake          | payload
//  req     | req_valid/ready    | operation, col, row, alpha
//  rsp     | rsp_valid/ready    | distance_fixed, distance_squared, found_flag
//  csr     | csr_write_enable   | csr_index, csr_data
// A write leaves the unit idle. A query offers its result after its window scan, or without a
// scan when the query pixel is opaque; an empty window still scans one pixel.
// The window scan reads one pixel per cycle from the single store port.
// Reset is synchronous; the store is not cleared. A stalled result holds the unit.
module windowed_nearest_opaque_distance_unit #(
   parameter int MAX_WIDTH  = wnod_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wnod_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = wnod_pkg::MAX_RADIUS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_col,
   input  logic [7:0]  req_row,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_distance_fixed,
   output logic [9:0]  rsp_distance_squared,
   output logic        rsp_found_flag,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import wnod_pkg::*;
   cmd_type cmd;
   status_type status;

   wnod_controller u_ctrl (.clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .cmd, .status);

   wnod_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS)) u_dp (.clock, .reset, .cmd, .status,
      .csr_write_enable, .csr_index, .csr_data, .req_col, .req_row, .req_alpha,
      .rsp_distance_fixed, .rsp_distance_squared, .rsp_found_flag);
endmodule

// ===== hdl/wnod_datapath.sv =====
// Datapath: pixel store, window scan, minimum search and bit-serial square root.
`include "windowed_nearest_opaque_distance_unit_macros.svh"
module wnod_datapath #(
   parameter int MAX_WIDTH  = wnod_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wnod_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = wnod_pkg::MAX_RADIUS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  wnod_pkg::cmd_type   cmd,
   output wnod_pkg::status_type status,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [8:0]          csr_data,
   input  logic [7:0]          req_col,
   input  logic [7:0]          req_row,
   input  logic [7:0]          req_alpha,
   output logic [12:0]         rsp_distance_fixed,
   output logic [9:0]          rsp_distance_squared,
   output logic                rsp_found_flag
);
   import wnod_pkg::*;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int CW = XW + 2;
   localparam int RYW = YW + 2;
   localparam int RW = $clog2(MAX_RADIUS + 1);
   localparam int DW = 2 * RW + 1;
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [1:0] mem [MAX_WIDTH*MAX_HEIGHT];
   logic [1:0] rd_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [4:0] radius_ff;
   logic [8:0] width_ff, height_ff;
   logic [CW-1:0] w_c, cx_ff, cx_in, sx_ff, ex_ff, qx_ff;
   logic [RYW-1:0] h_c, cy_ff, cy_in, ey_ff, qy_ff;
   logic [RW-1:0] rad_c;
   logic rd_valid_ff, qrd_ff, ctr_last;
   logic [CW-1:0] px_ff, pqx_ff;
   logic [RYW-1:0] py_ff, pqy_ff;
   logic [DW-1:0] best_ff, d2;
   logic found_ff;
   logic [CW-1:0] dx;
   logic [RYW-1:0] dy;
   logic [13:0] rem_ff;
   logic [12:0] rootp_ff;
   logic [25:0] val_ff;
   logic [4:0] cnt_ff;
   logic [16:0] trial;

   always_comb begin
      w_c = (width_ff == 9'd0) ? CW'(1) :
            (32'(width_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_ff);
      h_c = (height_ff == 9'd0) ? RYW'(1) :
            (32'(height_ff) > MAX_HEIGHT) ? RYW'(MAX_HEIGHT) : RYW'(height_ff);
      rad_c = (32'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data[4:0];
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign wr_addr = AW'(32'(req_row) * MAX_WIDTH + 32'(req_col));
   assign rd_addr = cmd.start_query ? wr_addr
                    : AW'(32'(cy_ff) * MAX_WIDTH + 32'(cx_ff));

   always_ff @(posedge clock) begin
      if (cmd.write_pixel && 32'(req_col) < MAX_WIDTH && 32'(req_row) < MAX_HEIGHT)
         mem[wr_addr] <= {req_alpha == FULL_ALPHA, req_alpha != 8'd0};
      rd_ff <= mem[rd_addr];
   end

   assign ctr_last = (cx_ff + CW'(1) >= ex_ff) && (cy_ff + RYW'(1) >= ey_ff);
   assign status.scan_last = ctr_last;
   assign status.opaque_hit = qrd_ff && rd_ff[1] && qx_ff < w_c && qy_ff < h_c;

   always_comb begin
      cx_in = cx_ff + CW'(1);
      cy_in = cy_ff;
      if (cx_in >= ex_ff) begin
         cx_in = sx_ff;
         cy_in = cy_ff + RYW'(1);
      end
   end

   assign dx = (pqx_ff > px_ff) ? pqx_ff - px_ff : px_ff - pqx_ff;
   assign dy = (pqy_ff > py_ff) ? pqy_ff - py_ff : py_ff - pqy_ff;
   assign d2 = DW'(dx[RW-1:0] * dx[RW-1:0]) + DW'(dy[RW-1:0] * dy[RW-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         qx_ff <= CW'(req_col);
         qy_ff <= RYW'(req_row);
         cx_ff <= (req_col > 8'(rad_c)) ? CW'(req_col) - CW'(rad_c) : '0;
         sx_ff <= (req_col > 8'(rad_c)) ? CW'(req_col) - CW'(rad_c) : '0;
         cy_ff <= (req_row > 8'(rad_c)) ? RYW'(req_row) - RYW'(rad_c) : '0;
         ex_ff <= (CW'(req_col) + CW'(rad_c) + CW'(1) > w_c) ? w_c
                  : CW'(req_col) + CW'(rad_c) + CW'(1);
         ey_ff <= (RYW'(req_row) + RYW'(rad_c) + RYW'(1) > h_c) ? h_c
                  : RYW'(req_row) + RYW'(rad_c) + RYW'(1);
      end else if (cmd.scan_step) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
      px_ff <= cx_ff;
      py_ff <= cy_ff;
      pqx_ff <= qx_ff;
      pqy_ff <= qy_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         best_ff <= DW'(rad_c * rad_c);
         found_ff <= 1'b0;
      end else if (cmd.start_sqrt && status.opaque_hit) begin
         best_ff <= '0;
         found_ff <= 1'b1;
      end else if (rd_valid_ff && rd_ff[0] && d2 < best_ff) begin
         best_ff <= d2;
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         qrd_ff <= 1'b0;
         val_ff <= '0;
         rem_ff <= '0;
         rootp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_valid_ff <= cmd.scan_step;
         qrd_ff <= cmd.start_query;
         if (cmd.start_sqrt) begin
            val_ff <= status.opaque_hit ? 26'd0 : {10'(best_ff), 16'd0};
            rem_ff <= '0;
            rootp_ff <= '0;
            cnt_ff <= '0;
         end else if (cmd.sqrt_step) begin
            if (trial[16] == 1'b0) begin
               rem_ff <= trial[13:0];
               rootp_ff <= {rootp_ff[11:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[11:0], val_ff[25:24]};
               rootp_ff <= {rootp_ff[11:0], 1'b0};
            end
            val_ff <= {val_ff[23:0], 2'b00};
            cnt_ff <= cnt_ff + 5'd1;
         end
      end
   end

   assign trial = {1'b0, rem_ff, val_ff[25:24]} - {2'b00, rootp_ff, 2'b01};
   assign status.sqrt_done = cnt_ff == 5'd13;
   assign rsp_distance_fixed = rootp_ff;
   assign rsp_distance_squared = 10'(best_ff);
   assign rsp_found_flag = found_ff;

   `WNOD_ASSERT_IMP(a_found_below, clock, reset, rsp_found_flag && status.sqrt_done,
      32'(rsp_distance_squared) < MAX_RADIUS * MAX_RADIUS + 1)
   `WNOD_ASSERT_NEXT(a_cnt_hold, clock, reset, !cmd.sqrt_step && !cmd.start_sqrt,
      $stable(cnt_ff))
   `WNOD_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 5'd13)
endmodule

// ===== hdl/wnod_controller.sv =====
// Controller state machine sequencing writes, window scans and the square root.
`include "windowed_nearest_opaque_distance_unit_macros.svh"
module wnod_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wnod_pkg::cmd_type    cmd,
   input  wnod_pkg::status_type status
);
   import wnod_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CTR  = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [1:0] tail_ff, tail_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      tail_in = tail_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            if (req_operation == OP_WRITE) cmd.write_pixel = 1'b1;
            else begin
               cmd.start_query = 1'b1;
               state_in = S_CTR;
            end
         end
         S_CTR: if (status.opaque_hit) begin
            cmd.start_sqrt = 1'b1;
            state_in = S_SQRT;
         end else state_in = S_SCAN;
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_TAIL;
               tail_in = 2'd0;
            end
         end
         S_TAIL: begin
            tail_in = tail_ff + 2'd1;
            if (tail_ff == 2'd2) begin
               cmd.start_sqrt = 1'b1;
               state_in = S_SQRT;
            end
         end
         S_SQRT: if (status.sqrt_done) state_in = S_OUT;
            else cmd.sqrt_step = 1'b1;
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         tail_ff <= tail_in;
      end
   end

   `WNOD_ASSERT_IMP(a_excl, clock, reset, 1'b1, !(req_ready && rsp_valid))
   `WNOD_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `WNOD_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

// ===== bench/tb_windowed_nearest_opaque_distance_unit.sv =====
// Testbench of the windowed nearest distance unit: directed and random pixel writes and queries.
`timescale 1ns / 1ps
module tb_windowed_nearest_opaque_distance_unit;
   import wnod_pkg::*;

   typedef struct packed {
      logic [12:0] distance_fixed;
      logic [9:0]  distance_squared;
      logic        found_flag;
   } distance_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = OP_WRITE;
   logic [7:0]  req_col = '0;
   logic [7:0]  req_row = '0;
   logic [7:0]  req_alpha = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [12:0] rsp_distance_fixed;
   logic [9:0]  rsp_distance_squared;
   logic        rsp_found_flag;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_RADIUS;
   logic [8:0]  csr_data = '0;

   logic [1:0]  coverage_map [0:255][0:255];
   bit          pixel_written [0:255][0:255];
   int unsigned radius_cfg = 0;
   int unsigned width_cfg = 256;
   int unsigned height_cfg = 256;
   distance_result_type expected_distances[$];
   int          failures = 0;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   bit          bursty = 1'b1;
   int          burst_left = 0;
   localparam int WATCHDOG_LIMIT = 200000;

   windowed_nearest_opaque_distance_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned root_of(int unsigned v);
      int unsigned root = 0;
      int unsigned b = 1 << 30;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic logic [1:0] pixel_bits(int unsigned c, int unsigned r,
                                             int unsigned w, int unsigned h);
      if (c >= w || r >= h) return 2'b00;
      return coverage_map[c][r];
   endfunction

   function automatic distance_result_type nearest_distance(int unsigned x, int unsigned y);
      distance_result_type res;
      int unsigned w, h, rad, best, sx, sy, ex, ey, dx, dy, d2;
      bit found;
      w = (width_cfg < 1) ? 1 : (width_cfg > 256 ? 256 : width_cfg);
      h = (height_cfg < 1) ? 1 : (height_cfg > 256 ? 256 : height_cfg);
      rad = radius_cfg > 31 ? 31 : radius_cfg;
      if (pixel_bits(x, y, w, h) & 2'b10) begin
         res.distance_fixed = '0;
         res.distance_squared = '0;
         res.found_flag = 1'b1;
         return res;
      end
      best = rad * rad;
      found = 0;
      sx = (x > rad) ? x - rad : 0;
      sy = (y > rad) ? y - rad : 0;
      ex = x + rad + 1;
      if (ex > w) ex = w;
      ey = y + rad + 1;
      if (ey > h) ey = h;
      for (int unsigned j = sy; j < ey; j++) begin
         for (int unsigned i = sx; i < ex; i++) begin
            if (pixel_bits(i, j, w, h) & 2'b01) begin
               dx = (x > i) ? x - i : i - x;
               dy = (y > j) ? y - j : j - y;
               d2 = dx * dx + dy * dy;
               if (d2 < best) begin
                  best = d2;
                  found = 1;
               end
            end
         end
      end
      res.distance_fixed = 13'(root_of(best << 16));
      res.distance_squared = 10'(best);
      res.found_flag = found;
      return res;
   endfunction

   // A query may only touch pixels that have been written.
   function automatic bit window_written(int unsigned x, int unsigned y);
      int unsigned w, h, rad, sx, sy, ex, ey;
      w = width_cfg; h = height_cfg; rad = radius_cfg;
      if (x < w && y < h && !pixel_written[x][y]) return 0;
      sx = (x > rad) ? x - rad : 0;
      sy = (y > rad) ? y - rad : 0;
      ex = x + rad + 1; if (ex > w) ex = w;
      ey = y + rad + 1; if (ey > h) ey = h;
      for (int unsigned j = sy; j < ey; j++)
         for (int unsigned i = sx; i < ex; i++)
            if (!pixel_written[i][j]) return 0;
      return 1;
   endfunction

   task automatic send_item(logic op, logic [7:0] c, logic [7:0] r, logic [7:0] a);
      int gap;
      if (bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 8);
         end
         burst_left--;
      end
      req_valid = 1'b1;
      req_operation = op;
      req_col = c;
      req_row = r;
      req_alpha = a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_WRITE) begin
         coverage_map[c][r] = {a == FULL_ALPHA, a != 0};
         pixel_written[c][r] = 1'b1;
      end else begin
         expected_distances.push_back(nearest_distance(32'(c), 32'(r)));
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_distances.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [8:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_RADIUS: radius_cfg = 32'(value[4:0]);
         CSR_WIDTH:  width_cfg = 32'(value);
         default:    height_cfg = 32'(value);
      endcase
   endtask

   task automatic set_shape(int unsigned rad, int unsigned w, int unsigned h);
      write_register(CSR_RADIUS, 9'(rad));
      write_register(CSR_WIDTH, 9'(w));
      write_register(CSR_HEIGHT, 9'(h));
   endtask

   // Fills the area in use with random coverage; density is the percent chance that a pixel is covered.
   task automatic fill_image(int unsigned w, int unsigned h, int unsigned density);
      logic [7:0] a;
      for (int unsigned r = 0; r < h; r++)
         for (int unsigned c = 0; c < w; c++) begin
            if ($urandom_range(0, 99) < density)
               a = ($urandom_range(0, 1) != 0) ? FULL_ALPHA : 8'($urandom_range(1, 254));
            else
               a = 0;
            send_item(OP_WRITE, 8'(c), 8'(r), a);
         end
   endtask

   task automatic test_directed();
      set_shape(2, 4, 4);
      fill_image(4, 4, 0);
      send_item(OP_QUERY, 0, 0, 8'hFF);
      send_item(OP_WRITE, 3, 3, 8'd1);
      send_item(OP_QUERY, 2, 2, 8'h00);
      send_item(OP_WRITE, 1, 1, FULL_ALPHA);
      send_item(OP_QUERY, 1, 1, 8'h00);
      send_item(OP_QUERY, 0, 0, 8'h00);
      send_item(OP_WRITE, 255, 255, 8'hAA);
      send_item(OP_QUERY, 255, 255, 8'h55);
      send_item(OP_QUERY, 4, 0, 8'h00);
      write_register(CSR_RADIUS, 0);
      send_item(OP_QUERY, 1, 1, 8'h00);
      send_item(OP_QUERY, 3, 3, 8'h00);
      write_register(CSR_RADIUS, 31);
      send_item(OP_QUERY, 0, 3, 8'h00);
      send_item(OP_WRITE, 1, 1, 8'h00);
      send_item(OP_QUERY, 0, 0, 8'h00);
   endtask

   task automatic test_extremes();
      set_shape(31, 1, 1);
      send_item(OP_WRITE, 0, 0, 8'd128);
      send_item(OP_QUERY, 0, 0, 8'h00);
      send_item(OP_QUERY, 200, 17, 8'h00);
      set_shape(1, 256, 2);
      for (int c = 250; c < 256; c++) begin
         send_item(OP_WRITE, 8'(c), 8'd0, (c % 2) ? 8'd7 : 8'd0);
         send_item(OP_WRITE, 8'(c), 8'd1, 8'd0);
      end
      send_item(OP_QUERY, 255, 1, 8'h00);
      send_item(OP_QUERY, 252, 0, 8'h00);
   endtask

   task automatic test_random();
      int unsigned w, h, x, y;
      for (int phase = 0; phase < 3; phase++) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 6);
         set_shape($urandom_range(0, 31), w, h);
         fill_image(w, h, $urandom_range(5, 40));
         for (int k = 0; k < 10; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_item(OP_WRITE, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                         $urandom_range(0, 3) == 0 ? FULL_ALPHA : 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 4) == 0) begin
               x = $urandom_range(0, 255);
               y = $urandom_range(0, 255);
               if (window_written(x, y))
                  send_item(OP_QUERY, 8'(x), 8'(y), 8'($urandom_range(0, 255)));
            end else begin
               send_item(OP_QUERY, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)),
                         8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic test_back_pressure();
      set_shape(3, 6, 6);
      fill_image(6, 6, 30);
      hold_off = 1'b1;
      bursty = 1'b0;
      for (int k = 0; k < 8; k++)
         send_item(OP_QUERY, 8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)), 8'h00);
      bursty = 1'b1;
      wait_drained();
      send_item(OP_QUERY, 2, 2, 8'h00);
   endtask

   always @(posedge clock) begin
      if (!reset && hold_off) begin
         rsp_ready <= 1'b0;
      end else if (!reset) begin
         rsp_ready <= ($urandom_range(0, 9) < 7) || (($urandom & 32'h70) == 0);
      end
   end

   initial begin
      @(posedge clock);
      wait (hold_off);
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_distances.size() == 0) begin
            $error("unexpected result transfer");
            failures++;
         end else begin
            want = expected_distances.pop_front();
            if (rsp_distance_fixed !== want.distance_fixed) begin
               $error("distance_fixed: expected %0d, actual %0d",
                      want.distance_fixed, rsp_distance_fixed);
               failures++;
            end
            if (rsp_distance_squared !== want.distance_squared) begin
               $error("distance_squared: expected %0d, actual %0d",
                      want.distance_squared, rsp_distance_squared);
               failures++;
            end
            if (rsp_found_flag !== want.found_flag) begin
               $error("found_flag: expected %0d, actual %0d",
                      want.found_flag, rsp_found_flag);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_windowed_nearest_opaque_distance_unit: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_extremes();
      test_back_pressure();
      test_random();
      wait_drained();
      repeat (100) @(negedge clock);
      if (failures == 0 && expected_distances.size() == 0)
         $display("tb_windowed_nearest_opaque_distance_unit: PASS");
      else
         $display("tb_windowed_nearest_opaque_distance_unit: FAIL");
      $finish;
   end
endmodule

// ===== windowed_nearest_opaque_distance_unit.f =====
+incdir+hdl
hdl/wnod_pkg.sv
hdl/wnod_datapath.sv
hdl/wnod_controller.sv
hdl/windowed_nearest_opaque_distance_unit.sv
bench/tb_windowed_nearest_opaque_distance_unit.sv
